/* rtl/lpre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_pkg: shared types and constants of the record extractor
// Holds the configuration register map, the header length and the command
// that travels from the classifying front end to the output back end.
// ----------------------------------------------------------------------------
package lpre_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SKIP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_SKIP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_SKIP = 2'd2;

    // Size of the data block header: category byte plus 16-bit length.
    localparam logic [15:0] HDR_LEN = 16'd3;

    // What the back end has to produce for one accepted byte.
    typedef enum logic [1:0] {
        KIND_BODY,
        KIND_HDR,
        KIND_BAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] hdr;   // category byte (high) and length high byte (low)
        logic [7:0]  data;  // the byte that caused this command
        logic        last;  // data is the final byte of its block
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/lpre_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_in_if: raw byte channel
// Valid/ready channel that carries one byte of the recorded stream.
// ----------------------------------------------------------------------------
interface lpre_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface
`default_nettype wire

/* rtl/lpre_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_out_if: extracted byte channel
// Valid/ready channel that carries one byte of an extracted data block.
// ----------------------------------------------------------------------------
interface lpre_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       block_end;
    logic       bad_length;
    logic       run_end;

    modport source (output valid, output out_byte, output block_end,
                    output bad_length, output run_end, input ready);
    modport sink   (input valid, input out_byte, input block_end,
                    input bad_length, input run_end, output ready);
endinterface
`default_nettype wire

/* rtl/length_prefixed_record_extractor_unit.sv */
`default_nettype none
// Each result item goes through the command queue and then the output register.
// Throughput: one input item per cycle while results drain as fast as they appear.
// A header's third byte yields three result items, emitted one after another by
// the output stage; the command queue absorbs the difference.
// Reset: synchronous and active low; it clears the phase, counters, skip registers,
// command queue and output stage at once. There is no clearing pass.
// ----------------------------------------------------------------------------
// length_prefixed_record_extractor_unit: data block deframer
// Drops file header, record prefix and record suffix bytes from a recorded
// byte stream and passes each length-prefixed data block, header included,
// marking the final byte of every block.
// ----------------------------------------------------------------------------
module length_prefixed_record_extractor_unit
    import lpre_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lpre_in_if.sink                    i_in,
    lpre_out_if.source                 o_out
);

    // The front end decides, for every accepted item, which framing phase it
    // falls in. Skip bytes are simply counted and dropped. Header bytes are
    // held until the third one arrives; then either a header command (carrying the
    // three header bytes, which the back end emits in turn) or an error command is queued.
    // Body bytes each queue one command carrying the block-end flag.
    logic q_full;
    logic q_push;
    t_cmd q_cmd;

    // The back end empties the queue one command at a time and expands it into
    // output items. The output register holds a finished item until the sink takes it;
    // the next command is taken only when the register is empty or the sink is ready.
    logic q_not_empty;
    logic q_pop;
    t_cmd q_head;

    lpre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (q_cmd)
    );

    lpre_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_cmd       (q_cmd),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_head      (q_head)
    );

    lpre_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_not_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

/* rtl/lpre_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_front: byte classifier
// Tracks the framing phase, holds the skip registers and turns each accepted
// byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module lpre_front
    import lpre_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lpre_in_if.sink                    i_in,
    input  wire logic                  i_q_full,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    typedef enum logic [2:0] {
        PH_FILE,
        PH_PREFIX,
        PH_HEADER,
        PH_BODY,
        PH_SUFFIX,
        PH_HALT
    } t_phase;

    logic [15:0] r_file_skip;
    logic [15:0] r_prefix_skip;
    logic [15:0] r_suffix_skip;

    t_phase      r_phase, n_phase;
    logic [15:0] r_count, n_count;
    logic [15:0] r_hdr,   n_hdr;
    logic [15:0] r_len,   n_len;

    t_phase      ph1, ph2;
    logic [15:0] cnt1, cnt2;
    logic [15:0] lim0;
    logic        skip0;
    logic [15:0] len_w;
    logic [15:0] body_cnt;
    logic        accept;
    logic        cmd_valid;
    logic [7:0]  b;

    assign b         = i_in.data_byte;
    assign i_in.ready = !i_q_full;
    assign accept    = i_in.valid && i_in.ready;
    assign o_push    = accept && cmd_valid;

    // A finished skip phase hands the byte on in the same cycle. At most two
    // hand-overs happen: a file or suffix skip into the prefix skip, and the
    // prefix skip into the header.
    always_comb begin
        lim0  = (r_phase == PH_FILE)   ? r_file_skip :
                (r_phase == PH_PREFIX) ? r_prefix_skip : r_suffix_skip;
        skip0 = (r_phase == PH_FILE) || (r_phase == PH_PREFIX) ||
                (r_phase == PH_SUFFIX);
        if (skip0 && (r_count >= lim0)) begin
            ph1  = (r_phase == PH_PREFIX) ? PH_HEADER : PH_PREFIX;
            cnt1 = '0;
        end else begin
            ph1  = r_phase;
            cnt1 = r_count;
        end
        if ((ph1 == PH_PREFIX) && (cnt1 >= r_prefix_skip)) begin
            ph2  = PH_HEADER;
            cnt2 = '0;
        end else begin
            ph2  = ph1;
            cnt2 = cnt1;
        end
    end

    always_comb begin
        n_phase   = ph2;
        n_count   = cnt2;
        n_hdr     = r_hdr;
        n_len     = r_len;
        cmd_valid = 1'b0;
        len_w     = {r_hdr[7:0], b};
        body_cnt  = cnt2 + 16'd1;
        o_cmd     = '{kind: KIND_BODY, hdr: r_hdr, data: b, last: 1'b0};
        unique case (ph2)
            PH_FILE, PH_PREFIX, PH_SUFFIX: begin
                n_count = cnt2 + 16'd1;
            end
            PH_HEADER: begin
                if (cnt2 == 16'd0) begin
                    n_hdr   = {b, 8'h00};
                    n_count = 16'd1;
                end else if (cnt2 == 16'd1) begin
                    n_hdr   = {r_hdr[15:8], b};
                    n_count = 16'd2;
                end else begin
                    n_len     = len_w;
                    cmd_valid = 1'b1;
                    if (len_w < HDR_LEN) begin
                        o_cmd.kind = KIND_BAD;
                        n_phase    = PH_HALT;
                        n_count    = '0;
                    end else begin
                        o_cmd.kind = KIND_HDR;
                        o_cmd.last = (len_w == HDR_LEN);
                        if (len_w == HDR_LEN) begin
                            n_phase = PH_SUFFIX;
                            n_count = '0;
                        end else begin
                            n_phase = PH_BODY;
                            n_count = HDR_LEN;
                        end
                    end
                end
            end
            PH_BODY: begin
                cmd_valid  = 1'b1;
                o_cmd.last = (body_cnt >= r_len);
                n_count    = body_cnt;
                if (body_cnt >= r_len) begin
                    n_phase = PH_SUFFIX;
                    n_count = '0;
                end
            end
            default: begin
                // Halted: every byte is dropped.
                n_phase = PH_HALT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_skip   <= '0;
            r_prefix_skip <= '0;
            r_suffix_skip <= '0;
            r_phase       <= PH_FILE;
            r_count       <= '0;
            r_hdr         <= '0;
            r_len         <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FILE_SKIP:   r_file_skip   <= i_cfg_data;
                    CFG_PREFIX_SKIP: r_prefix_skip <= i_cfg_data;
                    CFG_SUFFIX_SKIP: r_suffix_skip <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_hdr   <= n_hdr;
                r_len   <= n_len;
            end
        end
    end

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALT) |=> (r_phase == PH_HALT))
        else $error("halted extractor left the halt phase");

    a_bad_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (o_cmd.kind == KIND_BAD)) |=> (r_phase == PH_HALT))
        else $error("bad length did not halt the extractor");

endmodule
`default_nettype wire

/* rtl/lpre_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_queue: command queue
// Small first-in first-out buffer that decouples the classifier from the
// output stage.
// ----------------------------------------------------------------------------
module lpre_queue
    import lpre_pkg::*;
#(
    parameter int unsigned Depth = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_cmd      o_head
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

    t_cmd            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full      = (r_count == CntW'(Depth));
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_not_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push |-> !o_full) and (r_count <= CntW'(Depth)))
        else $error("command queue overflow");

endmodule
`default_nettype wire

/* rtl/lpre_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpre_back: result expander
// Turns queued commands into output items, three for a header and one
// otherwise, through a registered output stage.
// ----------------------------------------------------------------------------
module lpre_back
    import lpre_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_cmd      i_head,
    output logic      o_pop,
    lpre_out_if.source o_out
);

    localparam logic [1:0] SUB_CAT    = 2'd0;
    localparam logic [1:0] SUB_LEN_HI = 2'd1;

    logic [1:0] r_sub;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_bad;
    logic       r_run;

    logic [7:0] sel_byte;
    logic       sel_end, sel_bad, sel_final;
    logic       load;

    always_comb begin
        sel_byte  = i_head.data;
        sel_end   = i_head.last;
        sel_bad   = 1'b0;
        sel_final = 1'b1;
        unique case (i_head.kind)
            KIND_HDR: begin
                if (r_sub == SUB_CAT) begin
                    sel_byte  = i_head.hdr[15:8];
                    sel_end   = 1'b0;
                    sel_final = 1'b0;
                end else if (r_sub == SUB_LEN_HI) begin
                    sel_byte  = i_head.hdr[7:0];
                    sel_end   = 1'b0;
                    sel_final = 1'b0;
                end
            end
            KIND_BAD: begin
                sel_byte = '0;
                sel_end  = 1'b0;
                sel_bad  = 1'b1;
            end
            default: ;
        endcase
    end

    assign load  = i_valid && (!r_valid || o_out.ready);
    assign o_pop = load && sel_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub   <= SUB_CAT;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= sel_final ? SUB_CAT : r_sub + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_end  <= sel_end;
            r_bad  <= sel_bad;
            r_run  <= sel_final;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.block_end  = r_end;
    assign o_out.bad_length = r_bad;
    assign o_out.run_end    = r_run;

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != SUB_CAT) |-> (i_valid && (i_head.kind == KIND_HDR)))
        else $error("header expansion lost its queued command");

endmodule
`default_nettype wire
